>>> hdl/rgb_reflect_color_sampler_top_macros.svh
// Assertion macros for the reflective color sampler checker.
// Depends on nothing; included by the checker file only.
`ifndef RGB_REFLECT_COLOR_SAMPLER_TOP_MACROS_SVH
`define RGB_REFLECT_COLOR_SAMPLER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RCS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RCS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/rcs_pkg.sv
// Shared constants for the reflective color sampler: field widths, beat layout,
// register indexes and reset values. No dependencies.
package rcs_pkg;

    localparam int SAMPLE_W    = 10;
    localparam int LEVEL_W     = 8;
    localparam int LED_W       = 3;
    localparam int PERIOD_W    = 16;
    localparam int TICK_W      = 17;
    localparam int NUM_W       = 18;   // |sample - black| * 255
    localparam int CNT_W       = 5;    // holds NUM_W
    localparam int CH_W        = 2;
    localparam int NCH         = 3;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = 1;

    // Output tdata layout, lowest bit first
    localparam int LED_LSB     = 0;
    localparam int RED_LSB     = LED_LSB + LED_W;
    localparam int GREEN_LSB   = RED_LSB + LEVEL_W;
    localparam int BLUE_LSB    = GREEN_LSB + LEVEL_W;
    localparam int PACK_W      = BLUE_LSB + LEVEL_W;

    localparam int APB_AW      = 5;
    localparam int APB_DW      = 32;
    localparam int IDX_W       = 3;

    localparam logic [IDX_W-1:0] REG_PERIOD      = 3'd0;
    localparam logic [IDX_W-1:0] REG_WHITE_RED   = 3'd1;
    localparam logic [IDX_W-1:0] REG_WHITE_GREEN = 3'd2;
    localparam logic [IDX_W-1:0] REG_WHITE_BLUE  = 3'd3;
    localparam logic [IDX_W-1:0] REG_BLACK_RED   = 3'd4;
    localparam logic [IDX_W-1:0] REG_BLACK_GREEN = 3'd5;
    localparam logic [IDX_W-1:0] REG_BLACK_BLUE  = 3'd6;

    localparam logic [CH_W-1:0] CH_RED   = 2'd0;
    localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
    localparam logic [CH_W-1:0] CH_BLUE  = 2'd2;
    localparam logic [CH_W-1:0] CH_NONE  = 2'd3;

    localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd300;
    localparam logic [SAMPLE_W-1:0] WHITE_RST  = 10'd1023;
    localparam logic [SAMPLE_W-1:0] BLACK_RST  = 10'd0;
    localparam logic [TICK_W-1:0]   TICK_MAX   = 17'h1FFFF;
    localparam logic [LEVEL_W-1:0]  LEVEL_MAX  = 8'd255;

endpackage

>>> hdl/rgb_reflect_color_sampler_top.sv
// Reflective RGB color sampler: tick counter, LED sequencing and a shared
// restoring divider that maps one ADC sample per period onto 0..255.
// Depends on rcs_pkg.
//
//  channel   | dir | handshake                  | content
//  ----------+-----+----------------------------+---------------------------------
//  s_axis    | in  | tvalid/tready              | tdata: light_sample
//  m_axis    | out | tvalid/tready              | tdata: led, red, green, blue
//            |     |                            | tuser: updated
//  apb       | in  | psel/penable/pwrite/pready | period, white x3, black x3
//
// A tick beat that only counts or restarts the period goes from IDLE through FIN
// back to IDLE before the next accept. A sampling tick loads the operands on accept,
// runs the shared subtractor in DIV once per quotient bit, then posts the result in FIN.
// Reset is synchronous, active low; it restores the register defaults.
// The result register frees the input side: a new tick is taken while a
// finished beat still waits on m_axis_tready; a second result waits in FIN.
module rgb_reflect_color_sampler_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [rcs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [9:0] light_sample
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [rcs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // [2:0] led_drive,
                                                            // [10:3] red_level,
                                                            // [18:11] green_level,
                                                            // [26:19] blue_level
    output logic [rcs_pkg::OUT_TUSER_W-1:0] m_axis_tuser,   // [0] updated
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rcs_pkg::APB_AW-1:0]      paddr,
    input  logic [rcs_pkg::APB_DW-1:0]      pwdata,
    output logic [rcs_pkg::APB_DW-1:0]      prdata,
    output logic                            pready
);
    import rcs_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    // Configuration registers
    logic [PERIOD_W-1:0] r_period;
    logic [SAMPLE_W-1:0] r_white [NCH];
    logic [SAMPLE_W-1:0] r_black [NCH];

    // Sampler state
    logic [1:0]          r_state;
    logic [TICK_W-1:0]   r_ticks;
    logic [CH_W-1:0]     r_ch;
    logic                r_sampled;
    logic [LED_W-1:0]    r_led;
    logic [LEVEL_W-1:0]  r_level [NCH];

    // Divider and result path
    logic [CH_W-1:0]     r_wch;
    logic                r_upd;
    logic                r_zero;
    logic [SAMPLE_W-1:0] r_rem;
    logic [NUM_W-1:0]    r_quo;
    logic [SAMPLE_W-1:0] r_den;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [OUT_TUSER_W-1:0] r_out_user;

    logic                in_fire;
    logic [CH_W-1:0]     ch_cur;
    logic [CH_W-1:0]     ch_next;
    logic [TICK_W-1:0]   n_ticks;
    logic [TICK_W+2:0]   ticks_x5;
    logic                restart;
    logic                due;
    logic [SAMPLE_W-1:0] sample;
    logic [SAMPLE_W-1:0] blk;
    logic [SAMPLE_W-1:0] wht;
    logic                x_neg;
    logic                d_neg;
    logic [SAMPLE_W-1:0] x_mag;
    logic [SAMPLE_W-1:0] d_mag;
    logic [NUM_W-1:0]    num;
    logic [SAMPLE_W+1:0] trial;
    logic                q_bit;
    logic [NUM_W-1:0]    q_final;
    logic [LEVEL_W-1:0]  n_level;
    logic                wr_en;
    logic [IDX_W-1:0]    reg_idx;
    logic [PACK_W-1:0]   pack;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // A stray channel code of three counts as red.
    assign ch_cur  = (r_ch == CH_NONE) ? CH_RED : r_ch;
    assign ch_next = (ch_cur == CH_BLUE) ? CH_RED : ch_cur + 1'b1;

    // Saturating tick count; t > period/5 is the same test as 5t > period.
    assign n_ticks  = (r_ticks == TICK_MAX) ? r_ticks : r_ticks + 1'b1;
    assign ticks_x5 = {1'b0, n_ticks, 2'b00} + {3'b000, n_ticks};
    assign restart  = n_ticks > {1'b0, r_period};
    assign due      = (ticks_x5 > {4'b0000, r_period}) && !r_sampled;

    // Split the linear map into sign and magnitude; a negative quotient
    // or a flat calibration pair clamps to zero.
    assign sample = s_axis_tdata[SAMPLE_W-1:0];
    assign blk    = r_black[ch_cur];
    assign wht    = r_white[ch_cur];
    assign x_neg  = sample < blk;
    assign d_neg  = wht < blk;
    assign x_mag  = x_neg ? (blk - sample) : (sample - blk);
    assign d_mag  = d_neg ? (blk - wht) : (wht - blk);
    assign num    = {x_mag, 8'h00} - {8'h00, x_mag};

    // One restoring divide step per cycle on the shared subtractor.
    assign trial   = {1'b0, r_rem, r_quo[NUM_W-1]} - {2'b00, r_den};
    assign q_bit   = !trial[SAMPLE_W+1];
    assign q_final = {r_quo[NUM_W-2:0], q_bit};
    assign n_level = r_zero ? '0 :
                     (|q_final[NUM_W-1:LEVEL_W]) ? LEVEL_MAX : q_final[LEVEL_W-1:0];

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ticks     <= '0;
            r_ch        <= CH_RED;
            r_sampled   <= 1'b0;
            r_led       <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            for (int i = 0; i < NCH; i++) begin
                r_level[i] <= '0;
            end
        end else begin
            // FIN reloads the output register itself.
            if (r_out_valid && m_axis_tready && (r_state != ST_FIN)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        if (restart) begin
                            r_ch      <= ch_cur;
                            r_ticks   <= '0;
                            r_led     <= LED_W'(1) << ch_cur;
                            r_sampled <= 1'b0;
                            r_state   <= ST_FIN;
                        end else if (due) begin
                            r_ticks   <= n_ticks;
                            r_sampled <= 1'b1;
                            r_ch      <= ch_next;
                            r_cnt     <= CNT_W'(NUM_W);
                            r_state   <= ST_DIV;
                        end else begin
                            r_ch      <= ch_cur;
                            r_ticks   <= n_ticks;
                            r_state   <= ST_FIN;
                        end
                    end
                end
                ST_DIV: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_level[r_wch] <= n_level;
                        r_state        <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    // Hold the result until the output register frees up.
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign pack = {r_level[CH_BLUE], r_level[CH_GREEN], r_level[CH_RED], r_led};

    // Divider operands and result payload
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && in_fire) begin
            r_wch  <= ch_cur;
            r_upd  <= !restart && due;
            r_zero <= (d_mag == '0) || (x_neg != d_neg);
            r_rem  <= '0;
            r_quo  <= num;
            r_den  <= d_mag;
        end else if (r_state == ST_DIV) begin
            r_rem <= q_bit ? trial[SAMPLE_W-1:0] : {r_rem[SAMPLE_W-2:0], r_quo[NUM_W-1]};
            r_quo <= q_final;
        end
        if (r_state == ST_FIN && (!r_out_valid || m_axis_tready)) begin
            r_out_data <= OUT_TDATA_W'(pack);
            r_out_user <= OUT_TUSER_W'(r_upd);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // Configuration port: writes complete in the access phase, no wait states.
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[APB_AW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RST;
            for (int i = 0; i < NCH; i++) begin
                r_white[i] <= WHITE_RST;
                r_black[i] <= BLACK_RST;
            end
        end else if (wr_en) begin
            case (reg_idx)
                REG_PERIOD:      r_period          <= pwdata[PERIOD_W-1:0];
                REG_WHITE_RED:   r_white[CH_RED]   <= pwdata[SAMPLE_W-1:0];
                REG_WHITE_GREEN: r_white[CH_GREEN] <= pwdata[SAMPLE_W-1:0];
                REG_WHITE_BLUE:  r_white[CH_BLUE]  <= pwdata[SAMPLE_W-1:0];
                REG_BLACK_RED:   r_black[CH_RED]   <= pwdata[SAMPLE_W-1:0];
                REG_BLACK_GREEN: r_black[CH_GREEN] <= pwdata[SAMPLE_W-1:0];
                REG_BLACK_BLUE:  r_black[CH_BLUE]  <= pwdata[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_PERIOD:      prdata = APB_DW'(r_period);
            REG_WHITE_RED:   prdata = APB_DW'(r_white[CH_RED]);
            REG_WHITE_GREEN: prdata = APB_DW'(r_white[CH_GREEN]);
            REG_WHITE_BLUE:  prdata = APB_DW'(r_white[CH_BLUE]);
            REG_BLACK_RED:   prdata = APB_DW'(r_black[CH_RED]);
            REG_BLACK_GREEN: prdata = APB_DW'(r_black[CH_GREEN]);
            REG_BLACK_BLUE:  prdata = APB_DW'(r_black[CH_BLUE]);
            default:         prdata = '0;
        endcase
    end

endmodule

>>> hdl/rcs_checker.sv
// Port-level checker for the reflective color sampler, bound to the top level.
// Depends on rcs_pkg and rgb_reflect_color_sampler_top_macros.svh.
`include "rgb_reflect_color_sampler_top_macros.svh"

module rcs_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [rcs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [rcs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [rcs_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [rcs_pkg::APB_AW-1:0]      paddr,
    input logic [rcs_pkg::APB_DW-1:0]      pwdata,
    input logic [rcs_pkg::APB_DW-1:0]      prdata,
    input logic                            pready
);
    import rcs_pkg::*;

    logic in_fire;
    logic period_wr;

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign period_wr = psel && penable && pwrite && pready &&
                       (paddr[APB_AW-1:2] == REG_PERIOD);

    // Hold a stalled result beat.
    `RCS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result beat changed")

    // At most one LED lit in any result beat.
    `RCS_ASSERT_IMP(a_led_onehot, i_clk, i_rst_n, m_axis_tvalid, $onehot0(m_axis_tdata[LED_LSB+LED_W-1:LED_LSB]), "more than one LED enabled")

    // Drop ready in the cycle after each accepted tick.
    `RCS_ASSERT_NXT(a_busy_after_tick, i_clk, i_rst_n, in_fire, !s_axis_tready, "tick accepted back to back")

    // A period write reads back on the next cycle.
    `RCS_ASSERT_NXT(a_period_readback, i_clk, i_rst_n, period_wr, (paddr[APB_AW-1:2] != REG_PERIOD) || (prdata[PERIOD_W-1:0] == $past(pwdata[PERIOD_W-1:0])), "period register readback mismatch")

endmodule

bind rgb_reflect_color_sampler_top rcs_checker u_rcs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
);
